[src/mmts_pkg.sv]
// shared types and codes for the min/max tracking stack
`timescale 1ns / 1ps

package mmts_pkg;

   localparam int TAG_W   = 32;
   localparam int PRICE_W = 32;
   localparam int COUNT_W = 7;

   typedef logic [TAG_W-1:0]          tag_type;
   typedef logic signed [PRICE_W-1:0] price_type;
   typedef logic [1:0]                op_code_type;
   typedef logic [1:0]                status_type;
   typedef logic [COUNT_W-1:0]        count_type;

   // operation codes; the unused code behaves as a peek
   localparam op_code_type OP_PUSH = 2'd0;
   localparam op_code_type OP_POP  = 2'd1;
   localparam op_code_type OP_PEEK = 2'd2;

   // result status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   // one stack level: the entry itself and the max/min entries at or below it
   typedef struct packed {
      tag_type   tag;
      price_type price;
      tag_type   hi_tag;
      price_type hi_price;
      tag_type   lo_tag;
      price_type lo_price;
   } level_type;

   typedef enum logic {
      S_IDLE,
      S_POP_READ
   } state_type;

endpackage

[src/mmts_ifs.sv]
// request and response channel interfaces for the min/max tracking stack
`timescale 1ns / 1ps

interface mmts_req_if;
   import mmts_pkg::*;

   logic        valid;
   logic        ready;
   op_code_type operation;
   tag_type     item_tag;
   price_type   item_price;

   modport source(output valid, operation, item_tag, item_price, input ready);
   modport sink(input valid, operation, item_tag, item_price, output ready);
endinterface

interface mmts_rsp_if;
   import mmts_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   tag_type    result_tag;
   price_type  result_price;
   logic       has_entries;
   tag_type    highest_tag;
   price_type  highest_price;
   tag_type    lowest_tag;
   price_type  lowest_price;
   count_type  entry_count;

   modport source(output valid, status, result_tag, result_price, has_entries,
                  highest_tag, highest_price, lowest_tag, lowest_price, entry_count,
                  input ready);
   modport sink(input valid, status, result_tag, result_price, has_entries,
                highest_tag, highest_price, lowest_tag, lowest_price, entry_count,
                output ready);
endinterface

[src/mmts_level_ram.sv]
// synchronous level memory, one write port and one registered read port
`timescale 1ns / 1ps

module mmts_level_ram #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  mmts_pkg::level_type      wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output mmts_pkg::level_type      rd_data
);
   import mmts_pkg::*;

   level_type mem_ff [DEPTH];
   level_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/min_max_tracking_stack.sv]
// top level of the min/max tracking stack
`timescale 1ns / 1ps

// LIFO stack of (tag, price) entries that reports the highest- and lowest-priced
// entry held with every result; on equal prices the older entry keeps the title.
// Each level's record (entry plus the max/min entries at or below it) is kept in
// a synchronous level memory, and the top level's record is also held in
// registers. Push, peek and a pop or peek of an empty stack are answered in
// S_IDLE; a pop of a nonempty stack also passes through S_POP_READ, as the
// record of the level below the top comes from the level memory's registered
// read port. A new request is taken once the previous response is taken or is
// leaving. Push onto a full stack is dropped with a full status. The memory
// needs no clearing after reset: only levels below the fill count are ever read.
module min_max_tracking_stack #(
   parameter int STACK_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   mmts_req_if.sink     req_if,
   mmts_rsp_if.source   rsp_if
);
   import mmts_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   level_type         top_ff, top_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   tag_type           rsp_tag_ff;
   price_type         rsp_price_ff;
   logic              rsp_has_ff;
   level_type         rsp_mm_ff;
   count_type         rsp_count_ff;

   logic              req_fire;
   logic              is_push, is_pop, is_empty, is_full;
   logic              load_rsp, mem_wr_en;
   level_type         push_rec, rd_data;
   logic [ADDR_W-1:0] rd_addr;

   status_type        out_status;
   tag_type           out_tag;
   price_type         out_price;
   level_type         out_mm;
   logic [CNT_W-1:0]  out_count;

   // request decode
   assign req_fire = req_if.valid && req_if.ready;
   assign is_push  = (req_if.operation == OP_PUSH);
   assign is_pop   = (req_if.operation == OP_POP);
   assign is_empty = (fill_ff == '0);
   assign is_full  = (fill_ff == CNT_W'(STACK_DEPTH));

   // new top record for a push
   always_comb begin
      push_rec.tag      = req_if.item_tag;
      push_rec.price    = req_if.item_price;
      push_rec.hi_tag   = top_ff.hi_tag;
      push_rec.hi_price = top_ff.hi_price;
      push_rec.lo_tag   = top_ff.lo_tag;
      push_rec.lo_price = top_ff.lo_price;
      if (is_empty) begin
         push_rec.hi_tag   = req_if.item_tag;
         push_rec.hi_price = req_if.item_price;
         push_rec.lo_tag   = req_if.item_tag;
         push_rec.lo_price = req_if.item_price;
      end else if (req_if.item_price > top_ff.hi_price) begin
         push_rec.hi_tag   = req_if.item_tag;
         push_rec.hi_price = req_if.item_price;
      end else if (req_if.item_price < top_ff.lo_price) begin
         push_rec.lo_tag   = req_if.item_tag;
         push_rec.lo_price = req_if.item_price;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && !is_push && is_pop && !is_empty) begin
               state_in = S_POP_READ;
            end
         end
         S_POP_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state machine outputs
   always_comb begin
      req_if.ready = 1'b0;
      load_rsp     = 1'b0;
      mem_wr_en    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = !rsp_valid_ff || rsp_if.ready;
            load_rsp     = req_fire && !(is_pop && !is_empty);
            mem_wr_en    = req_fire && is_push && !is_full;
         end
         S_POP_READ: begin
            load_rsp = 1'b1;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   // record of the level below the top, read when a pop is taken
   assign rd_addr = ADDR_W'(fill_ff - CNT_W'(2));

   mmts_level_ram #(
      .DEPTH (STACK_DEPTH)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (push_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stack update and result values
   always_comb begin
      fill_in    = fill_ff;
      top_in     = top_ff;
      out_status = STATUS_OK;
      out_tag    = top_ff.tag;
      out_price  = top_ff.price;
      out_mm     = top_ff;
      out_count  = fill_ff;
      if (state_ff == S_POP_READ) begin
         // fill count already dropped; old top still cached
         top_in = (fill_ff != '0) ? rd_data : top_ff;
         out_mm = rd_data;
      end else if (req_fire) begin
         if (is_push) begin
            if (is_full) begin
               out_status = STATUS_FULL;
               out_tag    = req_if.item_tag;
               out_price  = req_if.item_price;
            end else begin
               top_in    = push_rec;
               fill_in   = fill_ff + CNT_W'(1);
               out_tag   = req_if.item_tag;
               out_price = req_if.item_price;
               out_mm    = push_rec;
               out_count = fill_ff + CNT_W'(1);
            end
         end else if (is_empty) begin
            out_status = STATUS_EMPTY;
            out_tag    = '0;
            out_price  = '0;
         end else if (is_pop) begin
            fill_in = fill_ff - CNT_W'(1);
         end
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // cached top record
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // response payload register; max/min read as zero when empty
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= out_status;
         rsp_tag_ff    <= out_tag;
         rsp_price_ff  <= out_price;
         rsp_has_ff    <= (out_count != '0);
         rsp_mm_ff     <= (out_count != '0) ? out_mm : '0;
         rsp_count_ff  <= COUNT_W'(out_count);
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.result_tag    = rsp_tag_ff;
   assign rsp_if.result_price  = rsp_price_ff;
   assign rsp_if.has_entries   = rsp_has_ff;
   assign rsp_if.highest_tag   = rsp_mm_ff.hi_tag;
   assign rsp_if.highest_price = rsp_mm_ff.hi_price;
   assign rsp_if.lowest_tag    = rsp_mm_ff.lo_tag;
   assign rsp_if.lowest_price  = rsp_mm_ff.lo_price;
   assign rsp_if.entry_count   = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // pop read phase is followed directly by idle
   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP_READ |=> state_ff == S_IDLE)
      else $error("pop read phase did not end");

   // fill count never passes the depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(STACK_DEPTH))
      else $error("fill count beyond stack depth");

   // a held response blocks new transfers
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_fire)
      else $error("request taken while response held");

   // max is never below min
   a_max_ge_min: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.has_entries |-> rsp_if.highest_price >= rsp_if.lowest_price)
      else $error("highest price below lowest price");

   // accepted push grows the stack by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_push && !is_full |=> fill_ff == $past(fill_ff) + CNT_W'(1))
      else $error("push did not grow the stack");
`endif

endmodule

[tb/mmts_checker.sv]
// scoreboard for the min/max tracking stack: predicts each response and compares it
`timescale 1ns / 1ps

module mmts_checker #(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   mmts_req_if         req_mon,
   mmts_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned open_count
);
   import mmts_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct {
      status_type status;
      tag_type    result_tag;
      price_type  result_price;
      logic       has_entries;
      tag_type    highest_tag;
      price_type  highest_price;
      tag_type    lowest_tag;
      price_type  lowest_price;
      count_type  entry_count;
   } stack_reply_type;

   // shadow copy of the stack contents and the per-level max/min positions
   tag_type     held_tag   [STACK_DEPTH];
   price_type   held_price [STACK_DEPTH];
   int unsigned best_idx   [STACK_DEPTH];
   int unsigned worst_idx  [STACK_DEPTH];
   int unsigned held_count;

   stack_reply_type reply_queue[$];

   // apply one operation to the shadow stack and build the reply it should produce
   function automatic stack_reply_type apply_operation(op_code_type op, tag_type tag,
                                                       price_type price);
      stack_reply_type r;
      int unsigned     pos;
      int unsigned     hi;
      int unsigned     lo;
      r.status       = STATUS_OK;
      r.result_tag   = tag;
      r.result_price = price;
      if (op == OP_PUSH) begin
         if (held_count >= STACK_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            pos             = held_count;
            held_tag[pos]   = tag;
            held_price[pos] = price;
            if (pos == 0) begin
               best_idx[0]  = 0;
               worst_idx[0] = 0;
            end else begin
               hi             = best_idx[pos-1];
               lo             = worst_idx[pos-1];
               best_idx[pos]  = hi;
               worst_idx[pos] = lo;
               // strict compares: on a tie the older entry keeps its place
               if (price > held_price[hi])
                  best_idx[pos] = pos;
               else if (price < held_price[lo])
                  worst_idx[pos] = pos;
            end
            held_count = pos + 1;
         end
      end else if (held_count == 0) begin
         r.status       = STATUS_EMPTY;
         r.result_tag   = '0;
         r.result_price = '0;
      end else begin
         // pop and peek both report the top entry; the spare code acts as peek
         r.result_tag   = held_tag[held_count-1];
         r.result_price = held_price[held_count-1];
         if (op == OP_POP)
            held_count = held_count - 1;
      end
      // max/min view after the operation
      if (held_count != 0) begin
         hi              = best_idx[held_count-1];
         lo              = worst_idx[held_count-1];
         r.has_entries   = 1'b1;
         r.highest_tag   = held_tag[hi];
         r.highest_price = held_price[hi];
         r.lowest_tag    = held_tag[lo];
         r.lowest_price  = held_price[lo];
      end else begin
         r.has_entries   = 1'b0;
         r.highest_tag   = '0;
         r.highest_price = '0;
         r.lowest_tag    = '0;
         r.lowest_price  = '0;
      end
      r.entry_count = count_type'(held_count);
      return r;
   endfunction

   task automatic note_failure(string what, logic [31:0] want, logic [31:0] got);
      if (fail_count < REPORT_LIMIT)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
      fail_count = fail_count + 1;
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want)
         note_failure(what, want, got);
   endtask

   initial begin
      fail_count = 0;
      open_count = 0;
      held_count = 0;
   end

   // watch both channels; responses are checked before the same-edge request is queued
   always @(posedge clock) begin
      stack_reply_type want;
      if (reset) begin
         held_count = 0;
         reply_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reply_queue.size() == 0) begin
               note_failure("unexpected response, status", '0, 32'(rsp_mon.status));
            end else begin
               want = reply_queue[0];
               reply_queue.delete(0);
               check_field("status", 32'(want.status), 32'(rsp_mon.status));
               check_field("result_tag", want.result_tag, rsp_mon.result_tag);
               check_field("result_price", want.result_price, rsp_mon.result_price);
               check_field("has_entries", 32'(want.has_entries), 32'(rsp_mon.has_entries));
               check_field("highest_tag", want.highest_tag, rsp_mon.highest_tag);
               check_field("highest_price", want.highest_price, rsp_mon.highest_price);
               check_field("lowest_tag", want.lowest_tag, rsp_mon.lowest_tag);
               check_field("lowest_price", want.lowest_price, rsp_mon.lowest_price);
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_mon.entry_count));
            end
         end
         if (req_mon.valid && req_mon.ready)
            reply_queue.push_back(apply_operation(req_mon.operation, req_mon.item_tag,
                                                  req_mon.item_price));
      end
      open_count = reply_queue.size();
   end

endmodule

[tb/tb_top.sv]
// top of the min/max tracking stack testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import mmts_pkg::*;

   localparam int          STACK_DEPTH  = 64;
   localparam int          RANDOM_OPS   = 1650;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 20;
   // operation code with no defined meaning; the block treats it as a peek
   localparam op_code_type OP_SPARE     = 2'd3;

   // price shapes for random pushes
   localparam int PRICE_ANY     = 0;
   localparam int PRICE_NARROW  = 1;
   localparam int PRICE_EXTREME = 2;

   logic        clock;
   logic        reset;
   bit          no_gaps;
   int unsigned fail_count;
   int unsigned open_count;
   int unsigned idle_cycles;

   mmts_req_if req_ch ();
   mmts_rsp_if rsp_ch ();

   min_max_tracking_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   mmts_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) scoreboard (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .fail_count(fail_count),
      .open_count(open_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // one request transfer: optional gap, then hold valid until ready is seen
   task automatic send_op(op_code_type op, tag_type tag, price_type price);
      int unsigned gap;
      bit          taken;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.item_tag   <= tag;
      req_ch.item_price <= price;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   function automatic price_type pick_price(int shape);
      price_type p;
      case (shape)
         PRICE_NARROW: p = price_type'($urandom_range(0, 8)) - price_type'(4);
         PRICE_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       p = 32'h7FFF_FFFF;
               1:       p = 32'h8000_0000;
               2:       p = '0;
               default: p = '1;
            endcase
         end
         default: p = $urandom;
      endcase
      return p;
   endfunction

   // stimulus: directed corner cases, then phases of push-heavy, pop-heavy and mixed traffic
   initial begin
      int          push_pct;
      int          shape;
      int unsigned roll;
      op_code_type op;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_PEEK;
      req_ch.item_tag   <= '0;
      req_ch.item_price <= '0;
      no_gaps           = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty stack handling
      send_op(OP_PEEK, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_op(OP_POP, 32'hDEAD_BEEF, 32'h8000_0000);
      send_op(OP_SPARE, '0, '0);
      // extremes of tag and price, ties on max and min
      send_op(OP_PUSH, 32'h0000_0000, 32'h0000_0000);
      send_op(OP_PUSH, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_op(OP_PUSH, 32'h1234_5678, 32'h8000_0000);
      send_op(OP_PUSH, 32'hA5A5_A5A5, 32'h7FFF_FFFF);
      send_op(OP_PUSH, 32'h5A5A_5A5A, 32'h8000_0000);
      send_op(OP_PUSH, 32'h0000_0001, 32'hFFFF_FFFF);
      send_op(OP_PEEK, '0, '0);
      send_op(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // unwind to empty, then underflow again
      repeat (6) send_op(OP_POP, $urandom, $urandom);
      send_op(OP_POP, '0, '0);
      send_op(OP_PEEK, '0, '0);

      // random phases; fill and drain phases run the stack into full and empty
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i % 100 == 0) begin
            case ((i / 100) % 4)
               0:       push_pct = 95;
               1:       push_pct = 10;
               2:       push_pct = 55;
               default: push_pct = $urandom_range(20, 80);
            endcase
            shape   = $urandom_range(PRICE_ANY, PRICE_EXTREME);
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(1, 100) <= push_pct) begin
            send_op(OP_PUSH, $urandom,
                    pick_price(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : shape));
         end else begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
               op = OP_POP;
            else if (roll < 9)
               op = OP_PEEK;
            else
               op = OP_SPARE;
            send_op(op, $urandom, $urandom);
         end
      end
      req_ch.valid <= 1'b0;

      // let every response come back, then a few quiet cycles
      while (open_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stall before each transfer
   initial begin
      int unsigned stall;
      bit          got;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do begin
            @(negedge clock);
            got = rsp_ch.valid;
            @(posedge clock);
         end while (!got);
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
